[rtl/ape_pkg.sv]
// Shared types, codes and speed-to-time tables for the actuator position estimator.
package ape_pkg;

  // Item action codes
  localparam logic [1:0] ACT_TICK       = 2'd0;
  localparam logic [1:0] ACT_SET_TARGET = 2'd1;
  localparam logic [1:0] ACT_RESTORE    = 2'd2;

  // Bridge direction codes
  localparam logic [1:0] DIR_STOP = 2'd0;
  localparam logic [1:0] DIR_FWD  = 2'd1;
  localparam logic [1:0] DIR_REV  = 2'd2;

  localparam int TICK_W     = 10;
  localparam int PCT_W      = 7;
  localparam int PWM_W      = 8;
  localparam int BASE_W     = 17;  // largest t0*d product is 90000
  localparam int SLOPE_W    = 11;  // largest t0-t1 is 2000
  localparam int DEN_W      = 6;   // largest pwm span is 50
  localparam int DIVISOR_W  = BASE_W;
  localparam int SCALE_W    = TICK_W + 7 + DEN_W;  // 100*tick*den < 2^23
  localparam int N_FWD      = 5;
  localparam int N_REV      = 4;

  localparam logic [TICK_W-1:0] TICK_RESET  = TICK_W'(50);
  localparam logic [PWM_W-1:0]  SPEED_RESET = PWM_W'(255);
  localparam logic [PCT_W-1:0]  PCT_MAX     = PCT_W'(100);

  localparam int FWD_PWM [N_FWD] = '{155, 165, 175, 205, 255};
  localparam int FWD_MS  [N_FWD] = '{6000, 4000, 3000, 1800, 800};
  localparam int REV_PWM [N_REV] = '{155, 175, 205, 255};
  localparam int REV_MS  [N_REV] = '{3000, 3000, 1500, 800};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_DIVIDE,
    ST_DONE
  } state_t;

  // One interpolation segment: time = (base - (s - p0) * slope) / den
  typedef struct packed {
    logic [BASE_W-1:0]  base;
    logic [SLOPE_W-1:0] slope;
    logic [PWM_W-1:0]   p0;
    logic [DEN_W-1:0]   den;
  } seg_t;

  typedef struct packed {
    logic load_item;
    logic load_div;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_busy;
  } status_t;

  function automatic seg_t seg_lookup(input logic rev, input logic [PWM_W-1:0] s);
    seg_t seg;
    logic found;
    int   d;
    seg   = '0;
    found = 1'b0;
    d     = 0;
    seg.den = DEN_W'(1);
    if (!rev) begin
      if (int'(s) <= FWD_PWM[0]) begin
        seg.base = BASE_W'(FWD_MS[0]);
      end else if (int'(s) >= FWD_PWM[N_FWD-1]) begin
        seg.base = BASE_W'(FWD_MS[N_FWD-1]);
      end else begin
        for (int i = 0; i < N_FWD - 1; i++) begin
          if (!found && int'(s) <= FWD_PWM[i+1]) begin
            found     = 1'b1;
            d         = FWD_PWM[i+1] - FWD_PWM[i];
            seg.den   = DEN_W'(d);
            seg.base  = BASE_W'(FWD_MS[i] * d);
            seg.slope = SLOPE_W'(FWD_MS[i] - FWD_MS[i+1]);
            seg.p0    = PWM_W'(FWD_PWM[i]);
          end
        end
      end
    end else begin
      if (int'(s) <= REV_PWM[0]) begin
        seg.base = BASE_W'(REV_MS[0]);
      end else if (int'(s) >= REV_PWM[N_REV-1]) begin
        seg.base = BASE_W'(REV_MS[N_REV-1]);
      end else begin
        for (int i = 0; i < N_REV - 1; i++) begin
          if (!found && int'(s) <= REV_PWM[i+1]) begin
            found     = 1'b1;
            d         = REV_PWM[i+1] - REV_PWM[i];
            seg.den   = DEN_W'(d);
            seg.base  = BASE_W'(REV_MS[i] * d);
            seg.slope = SLOPE_W'(REV_MS[i] - REV_MS[i+1]);
            seg.p0    = PWM_W'(REV_PWM[i]);
          end
        end
      end
    end
    return seg;
  endfunction

endpackage

[rtl/ape_if.sv]
// Item and result channel interfaces of the actuator position estimator.
interface ape_in_if #(parameter int PosW = 23);
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic signed [15:0] target_value;
  logic signed [15:0] speed_value;
  logic [PosW-1:0]    restore_position;

  modport source (output valid, action, target_value, speed_value, restore_position,
                  input ready);
  modport sink   (input valid, action, target_value, speed_value, restore_position,
                  output ready);
endinterface

interface ape_out_if #(parameter int PosW = 23);
  logic            valid;
  logic            ready;
  logic [1:0]      drive_dir;
  logic [7:0]      drive_pwm;
  logic [PosW-1:0] position;
  logic [6:0]      target_percent;
  logic            reached;
  logic            save_request;

  modport source (output valid, drive_dir, drive_pwm, position, target_percent, reached,
                  save_request, input ready);
  modport sink   (input valid, drive_dir, drive_pwm, position, target_percent, reached,
                  save_request, output ready);
endinterface

[rtl/ape_div.sv]
// Bit-serial restoring divider, one quotient bit per cycle.
module ape_div #(
  parameter int DividendW = 39,
  parameter int DivisorW  = 17
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [DividendW-1:0] dividend,
  input  logic [DivisorW-1:0]  divisor,
  output logic                 busy,
  output logic [DividendW-1:0] quotient
);

  localparam int CntW = $clog2(DividendW + 1);

  logic [CntW-1:0]      cnt;
  logic [DivisorW-1:0]  rem;
  logic [DivisorW-1:0]  dsr;
  logic [DividendW-1:0] quo;
  logic [DivisorW:0]    trial;
  logic [DivisorW:0]    diff;

  assign trial = {rem, quo[DividendW-1]};
  assign diff  = trial - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CntW'(DividendW);
    end else if (cnt != '0) begin
      cnt <= cnt - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dsr <= divisor;
      quo <= dividend;
    end else if (cnt != '0) begin
      if (!diff[DivisorW]) begin
        rem <= diff[DivisorW-1:0];
        quo <= {quo[DividendW-2:0], 1'b1};
      end else begin
        rem <= trial[DivisorW-1:0];
        quo <= {quo[DividendW-2:0], 1'b0};
      end
    end
  end

  assign busy     = (cnt != '0);
  assign quotient = quo;

endmodule

[rtl/ape_ctrl.sv]
// Sequencer for one item at a time and the result beat handshake.
module ape_ctrl
  import ape_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;
  logic   out_valid_next;
  logic   out_free;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_SETUP;
      end
      ST_SETUP: begin
        state_next = status.need_div ? ST_DIVIDE : ST_DONE;
      end
      ST_DIVIDE: begin
        if (!status.div_busy) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready       = 1'b0;
    cmd            = '0;
    out_valid_next = out_valid && !out_ready;
    unique case (state)
      ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.load_item = in_valid;
      end
      ST_SETUP: begin
        cmd.load_div = status.need_div;
      end
      ST_DIVIDE: begin
      end
      ST_DONE: begin
        cmd.commit = out_free;
        if (out_free) out_valid_next = 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

[rtl/ape_datapath.sv]
// Position, target and speed state, step computation and result register.
module ape_datapath
  import ape_pkg::*;
#(
  parameter int FRACTION_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [TICK_W-1:0]          cfg_wr_data,
  input  cmd_t                       cmd,
  output status_t                    status,
  input  logic [1:0]                 action,
  input  logic signed [15:0]         target_value,
  input  logic signed [15:0]         speed_value,
  input  logic [FRACTION_BITS+6:0]   restore_position,
  output logic [1:0]                 drive_dir,
  output logic [PWM_W-1:0]           drive_pwm,
  output logic [FRACTION_BITS+6:0]   position,
  output logic [PCT_W-1:0]           target_percent,
  output logic                       reached,
  output logic                       save_request
);

  localparam int PosW = FRACTION_BITS + 7;
  localparam int DivW = SCALE_W + FRACTION_BITS;
  localparam logic [PosW-1:0] FULL_SCALE = PosW'(100 * (2 ** FRACTION_BITS));
  localparam logic [PosW-1:0] SAVE_TH    = PosW'((2 ** FRACTION_BITS) / 10);

  // Item held for the duration of its processing
  logic [1:0]         act_q;
  logic signed [15:0] tv_q;
  logic signed [15:0] sv_q;
  logic [PosW-1:0]    rp_q;

  // Block state
  logic [TICK_W-1:0] tick_ms;
  logic [PosW-1:0]   est_pos;
  logic [PCT_W-1:0]  tgt_pct;
  logic [PWM_W-1:0]  speed;
  logic              moving;
  logic [PosW-1:0]   last_saved;
  logic              saved_valid;

  logic [PosW-1:0]   est_pos_next;
  logic [PCT_W-1:0]  tgt_pct_next;
  logic [PWM_W-1:0]  speed_next;
  logic              moving_next;
  logic [PosW-1:0]   last_saved_next;
  logic              saved_valid_next;
  logic [1:0]        dir_next;
  logic [PWM_W-1:0]  pwm_next;
  logic              reached_next;
  logic              save_next;

  logic [PosW-1:0]   tgt_fix;
  logic              go_fwd;
  logic              go_rev;
  logic [PosW-1:0]   gap;
  logic [PosW-1:0]   diff;
  logic [PosW-1:0]   rp_clamped;

  seg_t                        seg;
  logic [PWM_W-1:0]            ds;
  logic [PWM_W+SLOPE_W-1:0]    slope_prod;
  logic [PWM_W+SLOPE_W-1:0]    time_full;
  logic [TICK_W+6:0]           tick_scaled;
  logic [SCALE_W-1:0]          scale;
  logic [DivW-1:0]             dividend;
  logic [DIVISOR_W-1:0]        divisor;
  logic                        div_busy;
  logic [DivW-1:0]             quotient;
  logic                        overshoot;

  assign tgt_fix = {tgt_pct, {FRACTION_BITS{1'b0}}};
  assign go_fwd  = est_pos < tgt_fix;
  assign go_rev  = est_pos > tgt_fix;
  assign gap     = go_fwd ? (tgt_fix - est_pos) : (est_pos - tgt_fix);

  assign status.need_div = (act_q == ACT_TICK) && (go_fwd || go_rev);
  assign status.div_busy = div_busy;

  // Interpolated travel time and scaled interval
  assign seg         = seg_lookup(go_rev, speed);
  assign ds          = speed - seg.p0;
  assign slope_prod  = (PWM_W+SLOPE_W)'(ds) * (PWM_W+SLOPE_W)'(seg.slope);
  assign time_full   = (PWM_W+SLOPE_W)'(seg.base) - slope_prod;
  assign divisor     = time_full[DIVISOR_W-1:0];
  assign tick_scaled = (TICK_W+7)'(tick_ms) * (TICK_W+7)'(100);
  assign scale       = SCALE_W'(tick_scaled) * SCALE_W'(seg.den);
  assign dividend    = {scale, {FRACTION_BITS{1'b0}}};

  ape_div #(
    .DividendW(DivW),
    .DivisorW (DIVISOR_W)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.load_div),
    .dividend(dividend),
    .divisor (divisor),
    .busy    (div_busy),
    .quotient(quotient)
  );

  assign overshoot  = quotient > DivW'(gap);
  assign diff       = (est_pos > last_saved) ? (est_pos - last_saved) : (last_saved - est_pos);
  assign rp_clamped = (rp_q > FULL_SCALE) ? FULL_SCALE : rp_q;

  always_comb begin
    est_pos_next     = est_pos;
    tgt_pct_next     = tgt_pct;
    speed_next       = speed;
    moving_next      = moving;
    last_saved_next  = last_saved;
    saved_valid_next = saved_valid;
    dir_next         = DIR_STOP;
    pwm_next         = '0;
    reached_next     = 1'b0;
    save_next        = 1'b0;
    unique case (act_q)
      ACT_TICK: begin
        if (go_fwd) begin
          moving_next  = 1'b1;
          est_pos_next = overshoot ? tgt_fix : est_pos + quotient[PosW-1:0];
          dir_next     = DIR_FWD;
          pwm_next     = speed;
        end else if (go_rev) begin
          moving_next  = 1'b1;
          est_pos_next = overshoot ? tgt_fix : est_pos - quotient[PosW-1:0];
          dir_next     = DIR_REV;
          pwm_next     = speed;
        end else if (moving) begin
          if (!saved_valid || diff > SAVE_TH) begin
            save_next        = 1'b1;
            last_saved_next  = est_pos;
            saved_valid_next = 1'b1;
          end
          reached_next = 1'b1;
          moving_next  = 1'b0;
        end
      end
      ACT_SET_TARGET: begin
        priority if (tv_q < 16'sd0) tgt_pct_next = '0;
        else if (tv_q > 16'sd100) tgt_pct_next = PCT_MAX;
        else tgt_pct_next = tv_q[PCT_W-1:0];
        priority if (sv_q < 16'sd0) speed_next = '0;
        else if (sv_q > 16'sd255) speed_next = SPEED_RESET;
        else speed_next = sv_q[PWM_W-1:0];
        moving_next = 1'b1;
      end
      ACT_RESTORE: begin
        est_pos_next     = rp_clamped;
        tgt_pct_next     = rp_clamped[PosW-1:FRACTION_BITS];
        last_saved_next  = rp_clamped;
        saved_valid_next = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      act_q <= action;
      tv_q  <= target_value;
      sv_q  <= speed_value;
      rp_q  <= restore_position;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_ms <= TICK_RESET;
    end else if (cfg_wr_en) begin
      tick_ms <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      est_pos     <= '0;
      tgt_pct     <= '0;
      speed       <= SPEED_RESET;
      moving      <= 1'b0;
      saved_valid <= 1'b0;
    end else if (cmd.commit) begin
      est_pos     <= est_pos_next;
      tgt_pct     <= tgt_pct_next;
      speed       <= speed_next;
      moving      <= moving_next;
      saved_valid <= saved_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      last_saved     <= last_saved_next;
      drive_dir      <= dir_next;
      drive_pwm      <= pwm_next;
      position       <= est_pos_next;
      target_percent <= tgt_pct_next;
      reached        <= reached_next;
      save_request   <= save_next;
    end
  end

endmodule

[rtl/actuator_position_estimator.sv]
// Actuator position estimator: open-loop H-bridge actuator position tracking.
// A tick that moves the actuator runs the bit-serial divider, one quotient bit per cycle;
// other items skip the divide loop. One item is in flight, and the next beat is taken the
// cycle after the result is registered. Reset (rst, synchronous): position, target, motion,
// save history cleared, speed 255, tick 50 ms; no clearing pass.
module actuator_position_estimator
  import ape_pkg::*;
#(
  parameter int FRACTION_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [TICK_W-1:0] cfg_wr_data,
  ape_in_if.sink            items,
  ape_out_if.source         results
);

  // Control and status between the sequencer and the datapath
  cmd_t    cmd;
  status_t status;

  // The sequencer takes an item beat in idle, walks it through setup,
  // the divide loop when the tick moves the actuator, and a commit step.
  // Commit happens only once the result register is free or being drained,
  // so a finished result waits there while the next beat is accepted.
  ape_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (items.valid),
    .in_ready (items.ready),
    .out_valid(results.valid),
    .out_ready(results.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // The datapath holds the item, the estimator state and the result register.
  // It interpolates the travel time from the speed tables, feeds the divider
  // with 100 * interval * 2^FRACTION_BITS * span over span times the interpolated time,
  // and at commit moves the position, clamped at the target.
  ape_datapath #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .cmd             (cmd),
    .status          (status),
    .action          (items.action),
    .target_value    (items.target_value),
    .speed_value     (items.speed_value),
    .restore_position(items.restore_position),
    .drive_dir       (results.drive_dir),
    .drive_pwm       (results.drive_pwm),
    .position        (results.position),
    .target_percent  (results.target_percent),
    .reached         (results.reached),
    .save_request    (results.save_request)
  );

endmodule

[sim/tb_actuator_position_estimator.sv]
// Self-checking testbench for the actuator position estimator: directed and random beats.
module tb_actuator_position_estimator;
  import ape_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC        = 16;
  localparam int POS_W       = FRAC + 7;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 400;
  localparam int N_PHASES    = 6;

  // Action code the block must ignore (no state change, plain status result)
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  localparam longint unsigned FULL_SCALE  = 64'd100 << FRAC;
  localparam longint unsigned SAVE_MARGIN = (64'd1 << FRAC) / 10;
  localparam longint unsigned NEVER_SAVED = 64'hFF_FFFF;

  // Duty-to-full-travel-time breakpoints, forward and reverse
  localparam int FWD_DUTY [5] = '{155, 165, 175, 205, 255};
  localparam int FWD_TIME [5] = '{6000, 4000, 3000, 1800, 800};
  localparam int REV_DUTY [4] = '{155, 175, 205, 255};
  localparam int REV_TIME [4] = '{3000, 3000, 1500, 800};

  // Interval settings per random phase; a negative entry means pick one at random.
  // Zero freezes the estimate, 1023 lies past the nominal range, both must still work.
  localparam int PHASE_TICK   [N_PHASES] = '{1000, 1, 0, 1023, -1, 50};
  localparam int PHASE_BUDGET [N_PHASES] = '{70, 80, 30, 60, 100, 110};

  typedef struct packed {
    logic [1:0]       action;
    logic [15:0]      target_value;
    logic [15:0]      speed_value;
    logic [POS_W-1:0] restore_position;
  } order_t;

  typedef struct packed {
    logic [1:0]       drive_dir;
    logic [7:0]       drive_pwm;
    logic [POS_W-1:0] position;
    logic [6:0]       target_percent;
    logic             reached;
    logic             save_request;
  } drive_t;

  // Tracks the actuator estimate beat by beat and holds the bridge commands still owed.
  class drive_scoreboard;
    int              tick_ms   = 50;
    longint unsigned est       = 0;
    logic [6:0]      tgt_pct   = '0;
    int              duty      = 255;
    bit              armed     = 1'b0;
    longint unsigned saved_at  = NEVER_SAVED;
    drive_t          awaited_drives[$];
    int              mismatches = 0;
    int              moves = 0, arrivals = 0, saves = 0, restores = 0;

    // Step per tick: 100 * interval * 2^FRAC / interpolated travel time, truncated
    function longint unsigned travel_step(input bit rev);
      longint pts[5];
      longint ms[5];
      longint num, den;
      int     n;
      bit     found;
      n = rev ? 4 : 5;
      for (int i = 0; i < n; i++) begin
        pts[i] = rev ? REV_DUTY[i] : FWD_DUTY[i];
        ms[i]  = rev ? REV_TIME[i] : FWD_TIME[i];
      end
      den   = 1;
      num   = ms[n-1];
      found = 1'b0;
      if (duty <= pts[0]) begin
        num = ms[0];
      end else if (duty < pts[n-1]) begin
        for (int i = 0; i < n - 1; i++) begin
          if (!found && duty >= pts[i] && duty <= pts[i+1]) begin
            found = 1'b1;
            den   = pts[i+1] - pts[i];
            num   = ms[i] * den - (duty - pts[i]) * (ms[i] - ms[i+1]);
          end
        end
      end
      return ((longint'(100) * tick_ms) << FRAC) * den / num;
    endfunction

    function void note_item(input order_t o);
      longint          tv, sv;
      longint unsigned rp, goal, st, diff;
      drive_t          d;
      d  = '0;
      tv = $signed(o.target_value);
      sv = $signed(o.speed_value);
      case (o.action)
        ACT_SET_TARGET: begin
          if (tv < 0) tgt_pct = '0;
          else if (tv > 100) tgt_pct = PCT_MAX;
          else tgt_pct = 7'(tv);
          if (sv < 0) duty = 0;
          else if (sv > 255) duty = 255;
          else duty = int'(sv);
          armed = 1'b1;
        end
        ACT_RESTORE: begin
          rp = o.restore_position;
          if (rp > FULL_SCALE) rp = FULL_SCALE;
          est      = rp;
          tgt_pct  = 7'(rp >> FRAC);
          saved_at = rp;
          restores++;
        end
        ACT_TICK: begin
          goal = tgt_pct;
          goal = goal << FRAC;
          if (est < goal) begin
            st          = travel_step(1'b0);
            armed       = 1'b1;
            est         = (st > goal - est) ? goal : est + st;
            d.drive_dir = DIR_FWD;
            d.drive_pwm = 8'(duty);
            moves++;
          end else if (est > goal) begin
            st          = travel_step(1'b1);
            armed       = 1'b1;
            est         = (st > est - goal) ? goal : est - st;
            d.drive_dir = DIR_REV;
            d.drive_pwm = 8'(duty);
            moves++;
          end else if (armed) begin
            if (saved_at == NEVER_SAVED) diff = SAVE_MARGIN + 1;
            else if (est > saved_at) diff = est - saved_at;
            else diff = saved_at - est;
            if (diff > SAVE_MARGIN) begin
              d.save_request = 1'b1;
              saved_at       = est;
              saves++;
            end
            d.reached = 1'b1;
            armed     = 1'b0;
            arrivals++;
          end
        end
        default: ;
      endcase
      d.position       = POS_W'(est);
      d.target_percent = tgt_pct;
      awaited_drives.push_back(d);
    endfunction

    task report(input string what, input logic [63:0] got, input logic [63:0] want);
      mismatches++;
      $display("MISMATCH t=%0t %s: got %0d, wanted %0d", $time, what, got, want);
    endtask

    task check_result(input drive_t got);
      drive_t want;
      if (awaited_drives.size() == 0) begin
        report("result with nothing outstanding", got.position, 0);
        return;
      end
      want = awaited_drives.pop_front();
      if (got.drive_dir !== want.drive_dir) report("drive_dir", got.drive_dir, want.drive_dir);
      if (got.drive_pwm !== want.drive_pwm) report("drive_pwm", got.drive_pwm, want.drive_pwm);
      if (got.position !== want.position) report("position", got.position, want.position);
      if (got.target_percent !== want.target_percent)
        report("target_percent", got.target_percent, want.target_percent);
      if (got.reached !== want.reached) report("reached", got.reached, want.reached);
      if (got.save_request !== want.save_request)
        report("save_request", got.save_request, want.save_request);
    endtask
  endclass

  logic              clk;
  logic              rst;
  logic              cfg_wr_en;
  logic [TICK_W-1:0] cfg_wr_data;

  ape_in_if  #(.PosW(POS_W)) item_bus ();
  ape_out_if #(.PosW(POS_W)) result_bus ();

  actuator_position_estimator #(
    .FRACTION_BITS (FRAC)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .items       (item_bus),
    .results     (result_bus)
  );

  drive_scoreboard sb = new();

  int     cycle_count       = 0;
  int     beats_in          = 0;
  int     ignored_beats     = 0;
  int     intervals_written = 0;
  bit     quiet             = 1'b0;  // set for the closing phase: no idling on either side
  bit     held_off          = 1'b0;
  drive_t seen_drive;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Watchdog: a run that stalls or loses a beat ends here.
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("Timeout after %0d cycles, %0d results outstanding",
             cycle_count, sb.awaited_drives.size());
    $display("CHECK FAILED");
    $finish;
  end

  // Result sink: short random stalls, plus one long hold-off once enough beats have gone in,
  // so the block fills up and has to push back on the item side.
  initial begin
    result_bus.ready <= 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      @(posedge clk);
      if (!held_off && !quiet && beats_in >= 150) begin
        result_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        held_off = 1'b1;
        result_bus.ready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        result_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        result_bus.ready <= 1'b1;
      end else begin
        result_bus.ready <= 1'b1;
      end
    end
  end

  // Sample result beats at the edge they are taken and compare against the oldest prediction.
  always @(posedge clk) begin
    if (rst === 1'b0 && result_bus.valid === 1'b1 && result_bus.ready === 1'b1) begin
      seen_drive.drive_dir      = result_bus.drive_dir;
      seen_drive.drive_pwm      = result_bus.drive_pwm;
      seen_drive.position       = result_bus.position;
      seen_drive.target_percent = result_bus.target_percent;
      seen_drive.reached        = result_bus.reached;
      seen_drive.save_request   = result_bus.save_request;
      sb.check_result(seen_drive);
    end
  end

  function automatic order_t make_order(input logic [1:0] act, input int tv, input int sv,
                                        input longint unsigned rp);
    order_t o;
    o.action           = act;
    o.target_value     = 16'(tv);
    o.speed_value      = 16'(sv);
    o.restore_position = POS_W'(rp);
    return o;
  endfunction

  // Present one beat, with an occasional idle burst ahead of it; hold it until taken.
  // The prediction is updated right at the accepting edge, so the sequence code below
  // can steer by the estimate.
  task automatic offer(input order_t o);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      item_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    item_bus.valid            <= 1'b1;
    item_bus.action           <= o.action;
    item_bus.target_value     <= o.target_value;
    item_bus.speed_value      <= o.speed_value;
    item_bus.restore_position <= o.restore_position;
    do @(posedge clk); while (item_bus.ready !== 1'b1);
    sb.note_item(o);
    beats_in++;
    if (o.action == ACT_UNUSED) ignored_beats++;
  endtask

  task automatic aim_at(input int tv, input int sv);
    offer(make_order(ACT_SET_TARGET, tv, sv, longint'($urandom)));
  endtask

  task automatic restore_to(input longint unsigned p);
    offer(make_order(ACT_RESTORE, $urandom, $urandom, p));
  endtask

  task automatic tick_once();
    offer(make_order(ACT_TICK, $urandom, $urandom, longint'($urandom)));
  endtask

  // Tick until the scoreboard predicts the arrival, or give up after cap ticks.
  task automatic run_to_target(input int cap);
    for (int k = 0; k < cap && sb.armed; k++) tick_once();
  endtask

  // Drop valid and drain every outstanding result before touching the register.
  task automatic settle();
    item_bus.valid <= 1'b0;
    while (sb.awaited_drives.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_interval(input int v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= TICK_W'(v);
    @(posedge clk);
    sb.tick_ms = v;
    cfg_wr_en <= 1'b0;
    intervals_written++;
  endtask

  // Mostly well-formed moves: optional restore, set target near the estimate, tick to arrival.
  // The rest is raw noise over every field and action, unused code included.
  task automatic random_sequence();
    int roll, cur, span, goal_pct, duty, burst;
    roll = $urandom_range(0, 99);
    if (roll < 70) begin
      if ($urandom_range(0, 4) == 0) begin
        if ($urandom_range(0, 2) == 0) restore_to(longint'($urandom_range(0, 100)) << FRAC);
        else restore_to(longint'($urandom_range(0, int'(FULL_SCALE))));
      end
      cur  = int'(sb.est >> FRAC);
      // keep travel short when each tick only moves a sliver
      span = (sb.tick_ms >= 50) ? 100 : (sb.tick_ms >= 5) ? 15 : 2;
      goal_pct = cur + $urandom_range(0, 2 * span) - span;
      if (sb.tick_ms < 5) duty = $urandom_range(180, 255);
      else duty = $urandom_range(0, 255);
      if ($urandom_range(0, 9) == 0)
        duty = $urandom_range(0, 1) ? $urandom_range(256, 32767) : -$urandom_range(1, 32768);
      aim_at(goal_pct, duty);
      run_to_target(40);
    end else begin
      burst = $urandom_range(1, 5);
      repeat (burst)
        offer(make_order(2'($urandom_range(0, 3)), $urandom, $urandom, longint'($urandom)));
    end
  endtask

  initial begin : stimulus
    int phase_start;
    int tick_setting;
    rst                       <= 1'b1;
    cfg_wr_en                 <= 1'b0;
    cfg_wr_data               <= '0;
    item_bus.valid            <= 1'b0;
    item_bus.action           <= ACT_TICK;
    item_bus.target_value     <= '0;
    item_bus.speed_value      <= '0;
    item_bus.restore_position <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at the reset interval of 50 ms.
    tick_once();                                   // idle at target, nothing armed
    offer(make_order(ACT_UNUSED, -1, -1, 64'h7F_FFFF));
    aim_at(-32768, 32767);                         // both clamps, target 0 speed 255
    tick_once();                                   // arrival from never-saved: must save
    aim_at(32767, -32768);                         // target 100, duty 0 below the table
    tick_once();
    tick_once();
    restore_to(64'h7F_FFFF);                       // all ones, clamped to full scale
    aim_at(100, 155);
    tick_once();                                   // arrival with no movement: no save
    restore_to((64'd50 << FRAC) + SAVE_MARGIN);    // exactly on the save threshold
    aim_at(50, 255);
    run_to_target(4);
    restore_to((64'd50 << FRAC) + SAVE_MARGIN + 1);  // one past the threshold
    aim_at(50, 200);
    run_to_target(4);
    restore_to(0);
    aim_at(3, 170);                                // forward interpolation
    run_to_target(6);
    aim_at(0, 180);                                // reverse interpolation
    run_to_target(6);

    // Random phases, each under its own tick interval.
    for (int ph = 0; ph < N_PHASES; ph++) begin
      settle();
      tick_setting = PHASE_TICK[ph];
      if (tick_setting < 0) tick_setting = $urandom_range(2, 999);
      write_interval(tick_setting);
      quiet       = (ph == N_PHASES - 1);
      phase_start = beats_in - ignored_beats;
      while (beats_in - ignored_beats - phase_start < PHASE_BUDGET[ph]) random_sequence();
    end

    settle();
    repeat (50) @(posedge clk);

    $display("Run covered %0d item beats: %0d moving ticks, %0d arrivals, %0d save requests,",
             beats_in, sb.moves, sb.arrivals, sb.saves);
    $display("  %0d restores, %0d interval settings and a %0d-cycle result hold-off",
             sb.restores, intervals_written, HOLD_CYCLES);
    if (sb.mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[actuator_position_estimator.f]
rtl/ape_pkg.sv
rtl/ape_if.sv
rtl/ape_div.sv
rtl/ape_ctrl.sv
rtl/ape_datapath.sv
rtl/actuator_position_estimator.sv
sim/tb_actuator_position_estimator.sv
